// ===== rtl/core/stt_pkg.sv =====
// Shared types, constants and helpers for the software timer table.
package stt_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int TIME_W    = 48;
	localparam int PER_W     = 32;
	localparam int TAG_W     = 16;
	localparam logic [TIME_W-1:0] MAX_TIME = {TIME_W{1'b1}};

	// Input commands
	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Result kinds
	localparam logic [2:0] KIND_ADDED   = 3'd0;
	localparam logic [2:0] KIND_FULL    = 3'd1;
	localparam logic [2:0] KIND_FIRED   = 3'd2;
	localparam logic [2:0] KIND_NONE    = 3'd3;
	localparam logic [2:0] KIND_CLEARED = 3'd4;

	localparam logic [31:0] UNTIL_NONE = 32'hFFFF_FFFF;
	localparam logic [31:0] UNTIL_SAT  = 32'h7FFF_FFFF;

	// One stored timer
	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [PER_W-1:0]  period;
		logic              periodic;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN,
		ST_PICK,
		ST_LOAD,
		ST_SEND
	} state_t;

	// Saturating due-time sum
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] now,
		input logic [PER_W-1:0] d);
		logic [TIME_W:0] s;
		s = {1'b0, now} + {{(TIME_W+1-PER_W){1'b0}}, d};
		return s[TIME_W] ? MAX_TIME : s[TIME_W-1:0];
	endfunction

endpackage

// ===== rtl/core/stt_ram.sv =====
// Timer entry memory: one write port, one registered read port.
module stt_ram #(
	parameter int DEPTH = stt_pkg::SLOTS_DEF,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  stt_pkg::entry_t  wdata,
	input  logic [AW-1:0]    raddr,
	output stt_pkg::entry_t  rdata
);

	stt_pkg::entry_t mem [DEPTH];

	// Write entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read entry, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/software_timer_table.sv =====
// Top level of the software timer table: control, scan and result output.
//
//  channel | dir | fields
//  s_*     | in  | tuser: cmd; tdata: now_ms, delay_ms, repeat_flag, tag
//  m_*     | out | tuser: kind; tlast: last; tdata: slot, fired_tag,
//          |     |   active_count, until_next_ms
//
// Every item scans all SLOTS entries through the entry memory read port (scan, drain
// and finish states); each fired tick result then passes pick, load and send, others only send.
// Reset clears valid bits, count and control; entry memory needs no clearing.
// A stalled m_tready holds the result; s_tready is high only when idle.
module software_timer_table #(
	parameter int SLOTS = stt_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [103:0]  s_tdata,  // now_ms[47:0], delay_ms[79:48], repeat_flag[80],
	                                // tag[96:81], zero fill
	input  logic [1:0]    s_tuser,  // cmd
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [63:0]   m_tdata,  // slot[3:0], fired_tag[19:4], active_count[24:20],
	                                // until_next_ms[56:25], zero fill
	output logic [2:0]    m_tuser,  // kind
	output logic          m_tlast
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	stt_pkg::state_t state_q, state_d;

	logic [SLOTS-1:0]          valid_q;
	logic [SLOTS-1:0]          mask_q;
	logic [CW-1:0]             cnt_q;
	logic [1:0]                cmd_q;
	logic [stt_pkg::TIME_W-1:0] now_q;
	logic [stt_pkg::TIME_W-1:0] earliest_q;
	logic                      add_ok_q;
	logic [IW-1:0]             add_slot_q;
	logic [stt_pkg::TAG_W-1:0] add_tag_q;
	logic [31:0]               until_q;
	logic [IW-1:0]             scan_idx_q;
	logic                      rd_vld_s1;
	logic [IW-1:0]             rd_idx_s1;
	logic [IW-1:0]             pick_idx_s1;

	logic [2:0]                out_kind_q;
	logic [3:0]                out_slot_q;
	logic [stt_pkg::TAG_W-1:0] out_tag_q;
	logic                      out_last_q;

	logic                      in_acc;
	logic [1:0]                in_cmd;
	logic [stt_pkg::TIME_W-1:0] in_now;
	logic [stt_pkg::PER_W-1:0] in_delay;
	logic                      in_rep;
	logic [stt_pkg::TAG_W-1:0] in_tag;

	logic                      free_found;
	logic [IW-1:0]             free_idx;
	logic [IW-1:0]             sel_idx;
	logic [IW-1:0]             raddr;
	logic                      we;
	logic [IW-1:0]             waddr;
	stt_pkg::entry_t           wdata;
	stt_pkg::entry_t           rdata;

	logic                      fire;
	logic                      keep;
	logic [stt_pkg::TIME_W-1:0] new_due;
	logic [stt_pkg::TIME_W-1:0] cand;
	logic [stt_pkg::TIME_W-1:0] diff;
	logic [31:0]               until_d;

	assign in_acc   = s_tvalid && s_tready;
	assign in_cmd   = s_tuser;
	assign in_now   = s_tdata[47:0];
	assign in_delay = s_tdata[79:48];
	assign in_rep   = s_tdata[80];
	assign in_tag   = s_tdata[96:81];

	// Find lowest free slot and lowest pending fired slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		sel_idx    = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
			if (mask_q[i]) begin
				sel_idx = IW'(i);
			end
		end
	end

	// Evaluate the entry read back during the scan
	always_comb begin
		fire = rd_vld_s1 && (cmd_q == stt_pkg::CMD_TICK) && valid_q[rd_idx_s1]
			&& (rdata.due != stt_pkg::MAX_TIME) && (now_q >= rdata.due);
		new_due = stt_pkg::sat_add(now_q, rdata.period);
		cand    = (fire && rdata.periodic) ? new_due : rdata.due;
		keep    = rd_vld_s1 && valid_q[rd_idx_s1] && !(fire && !rdata.periodic);
	end

	// Time until the earliest due timer
	always_comb begin
		diff = earliest_q - now_q;
		priority if (earliest_q == stt_pkg::MAX_TIME) begin
			until_d = stt_pkg::UNTIL_NONE;
		end else if (earliest_q <= now_q) begin
			until_d = '0;
		end else if (diff > {16'd0, stt_pkg::UNTIL_SAT}) begin
			until_d = stt_pkg::UNTIL_SAT;
		end else begin
			until_d = diff[31:0];
		end
	end

	// Select memory write: new timer at accept, reschedule during scan
	always_comb begin
		if (in_acc && (in_cmd == stt_pkg::CMD_ADD)) begin
			we    = free_found;
			waddr = free_idx;
			wdata = '{due: stt_pkg::sat_add(in_now, in_delay), period: in_delay,
				periodic: in_rep, tag: in_tag};
		end else begin
			we    = fire && rdata.periodic;
			waddr = rd_idx_s1;
			wdata = rdata;
			wdata.due = new_due;
		end
	end

	stt_ram #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			stt_pkg::ST_IDLE:  if (s_tvalid) state_d = stt_pkg::ST_SCAN;
			stt_pkg::ST_SCAN:  if (scan_idx_q == LAST_IDX) state_d = stt_pkg::ST_DRAIN;
			stt_pkg::ST_DRAIN: state_d = stt_pkg::ST_FIN;
			stt_pkg::ST_FIN: begin
				if ((cmd_q == stt_pkg::CMD_TICK) && (mask_q != '0)) begin
					state_d = stt_pkg::ST_PICK;
				end else begin
					state_d = stt_pkg::ST_SEND;
				end
			end
			stt_pkg::ST_PICK:  state_d = stt_pkg::ST_LOAD;
			stt_pkg::ST_LOAD:  state_d = stt_pkg::ST_SEND;
			stt_pkg::ST_SEND: begin
				if (m_tready) begin
					state_d = out_last_q ? stt_pkg::ST_IDLE : stt_pkg::ST_PICK;
				end
			end
			default: state_d = stt_pkg::ST_IDLE;
		endcase
	end

	// Handshake and read address
	always_comb begin
		s_tready = (state_q == stt_pkg::ST_IDLE);
		m_tvalid = (state_q == stt_pkg::ST_SEND);
		raddr    = (state_q == stt_pkg::ST_PICK) ? sel_idx : scan_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Valid bits, active count and fired mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cnt_q     <= '0;
			mask_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == stt_pkg::ST_SCAN);
			if (in_acc) begin
				mask_q <= '0;
				if (in_cmd == stt_pkg::CMD_CLEAR) begin
					valid_q <= '0;
					cnt_q   <= '0;
				end else if ((in_cmd == stt_pkg::CMD_ADD) && free_found) begin
					valid_q[free_idx] <= 1'b1;
					cnt_q             <= cnt_q + CW'(1);
				end
			end else if (fire) begin
				mask_q[rd_idx_s1] <= 1'b1;
				if (!rdata.periodic) begin
					valid_q[rd_idx_s1] <= 1'b0;
					cnt_q              <= cnt_q - CW'(1);
				end
			end else if (state_q == stt_pkg::ST_LOAD) begin
				mask_q[pick_idx_s1] <= 1'b0;
			end
		end
	end

	// Item capture, scan counter and earliest search
	always_ff @(posedge clk) begin
		rd_idx_s1   <= scan_idx_q;
		pick_idx_s1 <= sel_idx;
		if (in_acc) begin
			cmd_q      <= in_cmd;
			now_q      <= in_now;
			add_ok_q   <= free_found;
			add_slot_q <= free_idx;
			add_tag_q  <= in_tag;
			earliest_q <= stt_pkg::MAX_TIME;
			scan_idx_q <= '0;
		end else begin
			if (state_q == stt_pkg::ST_SCAN) begin
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			if (keep && (cand < earliest_q)) begin
				earliest_q <= cand;
			end
		end
		if (state_q == stt_pkg::ST_FIN) begin
			until_q <= until_d;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == stt_pkg::ST_FIN) begin
			out_last_q <= 1'b1;
			out_slot_q <= '0;
			out_tag_q  <= '0;
			unique case (cmd_q)
				stt_pkg::CMD_ADD: begin
					out_kind_q <= add_ok_q ? stt_pkg::KIND_ADDED : stt_pkg::KIND_FULL;
					if (add_ok_q) begin
						out_slot_q <= 4'(add_slot_q);
						out_tag_q  <= add_tag_q;
					end
				end
				stt_pkg::CMD_CLEAR: out_kind_q <= stt_pkg::KIND_CLEARED;
				default:            out_kind_q <= stt_pkg::KIND_NONE;
			endcase
		end else if (state_q == stt_pkg::ST_LOAD) begin
			out_kind_q <= stt_pkg::KIND_FIRED;
			out_slot_q <= 4'(pick_idx_s1);
			out_tag_q  <= rdata.tag;
			out_last_q <= ((mask_q & ~(SLOTS'(1) << pick_idx_s1)) == '0);
		end
	end

	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;
	assign m_tdata = {7'd0, until_q, 5'(cnt_q), out_tag_q, out_slot_q};

endmodule

// ===== rtl/core/stt_checker.sv =====
// Port checker for the software timer table, bound to the top level.
module stt_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          s_tvalid,
	input logic          s_tready,
	input logic [103:0]  s_tdata,
	input logic [1:0]    s_tuser,
	input logic          m_tvalid,
	input logic          m_tready,
	input logic [63:0]   m_tdata,
	input logic [2:0]    m_tuser,
	input logic          m_tlast
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Never take an item while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	// Single results are last and carry no slot or tag
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stt_pkg::KIND_FULL || m_tuser == stt_pkg::KIND_NONE
			|| m_tuser == stt_pkg::KIND_CLEARED) |-> m_tlast && (m_tdata[19:0] == '0))
		else $error("bad single result");

	// Clear leaves nothing active
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == stt_pkg::KIND_CLEARED)
			|-> (m_tdata[24:20] == '0) && (m_tdata[56:25] == stt_pkg::UNTIL_NONE))
		else $error("clear left timers active");

endmodule

bind software_timer_table stt_checker u_stt_checker (.*);

// ===== dv/software_timer_table_tb.sv =====
// Self-checking testbench for the software timer table.
`timescale 1ns / 1ps

module software_timer_table_tb;

	localparam int NSLOT = 16;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [15:0] tag;
		logic [4:0]  count;
		logic [31:0] until_ms;
		logic        last;
	} timer_result_t;

	// Expected-result store with its own copy of the timer table
	class timer_scoreboard;
		timer_result_t pending[$];
		int            errors;
		bit            live[NSLOT];
		logic [47:0]   due[NSLOT];
		logic [31:0]   per[NSLOT];
		bit            rep[NSLOT];
		logic [15:0]   owner[NSLOT];

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function logic [47:0] due_sum(logic [47:0] now, logic [31:0] d);
			logic [48:0] s;
			s = {1'b0, now} + {17'd0, d};
			return s[48] ? stt_pkg::MAX_TIME : s[47:0];
		endfunction

		// Predict the results of one accepted item and update the table
		function void note_item(logic [1:0] cmd, logic [47:0] now, logic [31:0] d,
			bit r, logic [15:0] t);
			timer_result_t q[$];
			timer_result_t e;
			int            n, k;
			logic [47:0]   early;
			logic [47:0]   gap;
			q = {};
			e = '0;
			if (cmd == stt_pkg::CMD_ADD) begin
				for (k = 0; k < NSLOT; k++) if (!live[k]) break;
				if (k < NSLOT) begin
					live[k] = 1; due[k] = due_sum(now, d); per[k] = d;
					rep[k] = r; owner[k] = t;
					e.kind = stt_pkg::KIND_ADDED; e.slot = 4'(k); e.tag = t;
				end else e.kind = stt_pkg::KIND_FULL;
				q.insert(q.size(), e);
			end else if (cmd == stt_pkg::CMD_TICK) begin
				for (k = 0; k < NSLOT; k++) begin
					if (!live[k] || due[k] == stt_pkg::MAX_TIME || now < due[k]) continue;
					e = '0; e.kind = stt_pkg::KIND_FIRED; e.slot = 4'(k); e.tag = owner[k];
					q.insert(q.size(), e);
					if (rep[k]) due[k] = due_sum(now, per[k]);
					else live[k] = 0;
				end
				if (q.size() == 0) begin
					e = '0; e.kind = stt_pkg::KIND_NONE; q.insert(q.size(), e);
				end
			end else begin
				if (cmd == stt_pkg::CMD_CLEAR) begin
					for (k = 0; k < NSLOT; k++) live[k] = 0;
					e.kind = stt_pkg::KIND_CLEARED;
				end else e.kind = stt_pkg::KIND_NONE;
				q.insert(q.size(), e);
			end
			n = 0;
			early = stt_pkg::MAX_TIME;
			for (k = 0; k < NSLOT; k++) if (live[k]) begin
				n++;
				if (due[k] < early) early = due[k];
			end
			gap = early - now;
			foreach (q[i]) begin
				q[i].count = 5'(n);
				if (early == stt_pkg::MAX_TIME) q[i].until_ms = stt_pkg::UNTIL_NONE;
				else if (early <= now) q[i].until_ms = '0;
				else if (gap > 48'h7FFF_FFFF) q[i].until_ms = stt_pkg::UNTIL_SAT;
				else q[i].until_ms = gap[31:0];
				q[i].last = (i == q.size() - 1);
				pending.insert(pending.size(), q[i]);
			end
		endfunction

		task check_result(timer_result_t got);
			timer_result_t x;
			if (pending.size() == 0) begin
				report("result with nothing expected");
				return;
			end
			x = pending.pop_front();
			if (got.kind != x.kind) report($sformatf("kind %0d exp %0d", got.kind, x.kind));
			if (got.slot != x.slot) report($sformatf("slot %0d exp %0d", got.slot, x.slot));
			if (got.tag != x.tag) report($sformatf("tag %h exp %h", got.tag, x.tag));
			if (got.count != x.count)
				report($sformatf("count %0d exp %0d", got.count, x.count));
			if (got.until_ms != x.until_ms)
				report($sformatf("until %h exp %h", got.until_ms, x.until_ms));
			if (got.last != x.last) report($sformatf("last %0d exp %0d", got.last, x.last));
		endtask
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_tvalid = 0;
	logic         s_tready;
	logic [103:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 0;
	logic [63:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	timer_scoreboard board = new();
	longint        cycles = 0;
	bit            stall_mode = 0;
	logic [47:0]   clock_ms = 0;

	software_timer_table u_top (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("software_timer_table_tb failed");
			$finish;
		end
	end

	// Check each result and stall the result side in alternating patterns
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			timer_result_t got;
			got.kind = m_tuser; got.slot = m_tdata[3:0]; got.tag = m_tdata[19:4];
			got.count = m_tdata[24:20]; got.until_ms = m_tdata[56:25]; got.last = m_tlast;
			board.check_result(got);
		end
		if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
		m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
	end

	// Send one item and wait for its acceptance
	task automatic send_item(logic [1:0] cmd, logic [47:0] now, logic [31:0] d,
		bit r, logic [15:0] t);
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {7'd0, t, r, d, now};
		do @(posedge clk); while (!s_tready);
		board.note_item(cmd, now, d, r, t);
	endtask

	task automatic idle_gap(int n);
		s_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		idle_gap(1);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Random item: mostly adds and ticks around a moving clock
	task automatic random_item();
		int          pick;
		logic [31:0] d;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: d = 0;
			1: d = $urandom;
			2: d = 32'hFFFF_FFFF;
			default: d = $urandom_range(0, 40);
		endcase
		if ($urandom_range(0, 49) == 0) clock_ms = 48'({$urandom, $urandom});
		else clock_ms = 48'(clock_ms + $urandom_range(0, 20));
		if (pick < 45)
			send_item(stt_pkg::CMD_ADD, clock_ms, d, 1'($urandom_range(0, 1)),
				16'($urandom));
		else if (pick < 93)
			send_item(stt_pkg::CMD_TICK, clock_ms, $urandom, 1'($urandom), 16'($urandom));
		else if (pick < 97)
			send_item(stt_pkg::CMD_CLEAR, clock_ms, $urandom, 1'($urandom), 16'($urandom));
		else send_item(CMD_SPARE, clock_ms, $urandom, 1'($urandom), 16'($urandom));
	endtask

	initial begin
		int burst;
		int gap;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty tick, fill past full, overflow, zero period, clear, spare
		send_item(stt_pkg::CMD_TICK, 48'd0, 0, 0, 0);
		send_item(stt_pkg::CMD_ADD, 48'd100, 32'd0, 1, 16'hFFFF);
		send_item(stt_pkg::CMD_ADD, stt_pkg::MAX_TIME - 5, 32'hFFFF_FFFF, 0, 16'h0000);
		send_item(stt_pkg::CMD_ADD, 48'd100, 32'hFFFF_FFFF, 1, 16'hA5A5);
		for (int i = 0; i < 14; i++)
			send_item(stt_pkg::CMD_ADD, 48'd100, 32'(i * 3), i[0], 16'(16'h5A00 + i));
		send_item(stt_pkg::CMD_ADD, 48'd100, 5, 0, 16'h1234);
		send_item(stt_pkg::CMD_TICK, 48'd110, 0, 0, 0);
		send_item(stt_pkg::CMD_TICK, stt_pkg::MAX_TIME - 1, 0, 0, 0);
		send_item(CMD_SPARE, 48'h0, 32'hFFFF_FFFF, 1, 16'hFFFF);
		send_item(stt_pkg::CMD_CLEAR, stt_pkg::MAX_TIME, 0, 0, 0);
		send_item(stt_pkg::CMD_TICK, stt_pkg::MAX_TIME, 0, 0, 0);
		drain();
		// Random bursts with gaps; while the item count is past 200 and below 230, pause for all results
		for (int i = 0; i < 480; i += burst) begin
			burst = $urandom_range(1, 20);
			for (int j = 0; j < burst; j++) random_item();
			if (i > 200 && i < 230) drain();
			else begin
				gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 40);
				if (gap > 0) idle_gap(gap);
			end
		end
		drain();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("software_timer_table_tb passed");
		else
			$display("software_timer_table_tb failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_ram.sv
rtl/core/software_timer_table.sv
rtl/core/stt_checker.sv
dv/software_timer_table_tb.sv
